/* sv/apdc_pkg.sv */
// Shared types, constants and register codes for the audio PLL divider calculator.
package apdc_pkg;

  // Field widths.
  localparam int unsigned REF_W    = 26;
  localparam int unsigned FS_W     = 18;
  localparam int unsigned TGT_W    = 32;
  localparam int unsigned QUO_W    = 32;
  localparam int unsigned NUM_SCL  = 8;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned IP_W     = 4;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Long division of (target << 28) by the reference: 60 quotient steps,
  // four steps in each pipeline stage.
  localparam int unsigned DIV_STEPS      = 60;
  localparam int unsigned STEPS_PER_STG  = 4;
  localparam int unsigned DIV_STAGES     = DIV_STEPS / STEPS_PER_STG;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VCO_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IP_MIN  = 3'd4;

  // Register reset values.
  localparam logic [31:0]       VCO_MIN_RST = 32'd90000000;
  localparam logic [31:0]       VCO_MAX_RST = 32'd100000000;
  localparam logic [REF_W-1:0]  REF_MIN_RST = 26'd8000000;
  localparam logic [REF_W-1:0]  REF_MAX_RST = 26'd33000000;
  localparam logic [IP_W-1:0]   IP_MIN_RST  = 4'd6;

  // Scalers {10,15,20,30,40,60,80,120} give 1024*s/10 =
  // {1024,1536,2048,3072,4096,6144,8192,12288}: either fs or 3*fs, shifted.
  localparam logic [NUM_SCL-1:0] SCL_TRIPLE = 8'b1010_1010;
  localparam logic [3:0] SCL_SHIFT [NUM_SCL] = '{
    4'd10, 4'd9, 4'd11, 4'd10, 4'd12, 4'd11, 4'd13, 4'd12
  };

  // Item state carried through the divider pipeline.
  typedef struct packed {
    logic [REF_W-1:0] ref_hz;
    logic [TGT_W-1:0] dvd;
    logic [REF_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [SEL_W-1:0] sel;
    logic             found;
    logic             ref_oor;
  } div_t;

endpackage

/* sv/apdc_select.sv */
// First stage: scaler targets, window selection and reference range check.
module apdc_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [apdc_pkg::REF_W-1:0]    ref_clock_hz_i,
  input  logic [apdc_pkg::FS_W-1:0]     sample_rate_hz_i,
  input  logic [31:0]                   vco_min_i,
  input  logic [31:0]                   vco_max_i,
  input  logic [apdc_pkg::REF_W-1:0]    ref_min_i,
  input  logic [apdc_pkg::REF_W-1:0]    ref_max_i,
  output logic                          vld_o,
  output apdc_pkg::div_t                stg_o
);

  logic [apdc_pkg::FS_W+1:0]  fs3;
  logic [apdc_pkg::TGT_W-1:0] tgt [apdc_pkg::NUM_SCL];
  logic [apdc_pkg::NUM_SCL-1:0] in_win;
  logic [apdc_pkg::TGT_W-1:0] best;
  logic [apdc_pkg::SEL_W-1:0] sel;
  logic                       found;
  apdc_pkg::div_t             stg_d, stg_q;
  logic                       vld_q;

  // Targets are fs or 3*fs shifted left; they rise with the index.
  assign fs3 = {2'b00, sample_rate_hz_i} + {1'b0, sample_rate_hz_i, 1'b0};

  always_comb begin
    for (int i = 0; i < apdc_pkg::NUM_SCL; i++) begin
      if (apdc_pkg::SCL_TRIPLE[i]) begin
        tgt[i] = apdc_pkg::TGT_W'({12'd0, fs3} << apdc_pkg::SCL_SHIFT[i]);
      end else begin
        tgt[i] = apdc_pkg::TGT_W'({14'd0, sample_rate_hz_i} << apdc_pkg::SCL_SHIFT[i]);
      end
      in_win[i] = (tgt[i] > vco_min_i) && (tgt[i] < vco_max_i);
    end
  end

  // Largest target in the window is the highest index in the window.
  always_comb begin
    best  = '0;
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < apdc_pkg::NUM_SCL; i++) begin
      if (in_win[i]) begin
        best  = tgt[i];
        sel   = apdc_pkg::SEL_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    stg_d.ref_hz  = ref_clock_hz_i;
    stg_d.dvd     = best;
    stg_d.rem     = '0;
    stg_d.quo     = '0;
    stg_d.sel     = sel;
    stg_d.found   = found;
    stg_d.ref_oor = (ref_clock_hz_i > ref_max_i) || (ref_clock_hz_i < ref_min_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

/* sv/apdc_div_stage.sv */
// One divider pipeline stage: four restoring division steps.
module apdc_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  apdc_pkg::div_t stg_i,
  output logic           vld_o,
  output apdc_pkg::div_t stg_o
);

  apdc_pkg::div_t       stg_d, stg_q;
  logic                 vld_q;
  logic [apdc_pkg::REF_W:0] trial;

  // Shift the next dividend bit into the remainder and subtract when it fits.
  always_comb begin
    stg_d = stg_i;
    trial = '0;
    for (int s = 0; s < apdc_pkg::STEPS_PER_STG; s++) begin
      trial     = {stg_d.rem, stg_d.dvd[apdc_pkg::TGT_W-1]};
      stg_d.dvd = {stg_d.dvd[apdc_pkg::TGT_W-2:0], 1'b0};
      if (trial >= {1'b0, stg_d.ref_hz}) begin
        trial     = trial - {1'b0, stg_d.ref_hz};
        stg_d.quo = {stg_d.quo[apdc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        stg_d.quo = {stg_d.quo[apdc_pkg::QUO_W-2:0], 1'b0};
      end
      stg_d.rem = trial[apdc_pkg::REF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

/* sv/apdc_finish.sv */
// Last stage: pre-divide doubling, zero-reference masking and result registers.
module apdc_finish (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  apdc_pkg::div_t                stg_i,
  input  logic [apdc_pkg::IP_W-1:0]     ip_min_i,
  output logic                          done_o,
  output logic [apdc_pkg::SEL_W-1:0]    scaler_index_o,
  output logic                          no_scaler_found_o,
  output logic                          ref_out_of_range_o,
  output logic                          ref_is_zero_o,
  output logic                          pre_divide_o,
  output logic [apdc_pkg::IP_W-1:0]     ratio_int_o,
  output logic [apdc_pkg::FRAC_W-1:0]   ratio_frac_o
);

  logic                          ref_zero;
  logic                          pre;
  logic [apdc_pkg::QUO_W-1:0]    ratio;
  logic                          done_q;
  logic [apdc_pkg::SEL_W-1:0]    sel_q;
  logic                          nsf_q, oor_q, zero_q, pre_q;
  logic [apdc_pkg::IP_W-1:0]     ip_q;
  logic [apdc_pkg::FRAC_W-1:0]   frac_q;

  // Ratio doubled when its integer part is below the minimum; zero ref gives 0.
  always_comb begin
    ref_zero = (stg_i.ref_hz == '0);
    pre      = 1'b0;
    ratio    = stg_i.quo;
    if (ref_zero) begin
      ratio = '0;
    end else if (stg_i.quo[apdc_pkg::QUO_W-1 -: apdc_pkg::IP_W] < ip_min_i) begin
      pre   = 1'b1;
      ratio = {stg_i.quo[apdc_pkg::QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= stg_i.found ? stg_i.sel : '0;
    nsf_q  <= ~stg_i.found;
    oor_q  <= stg_i.ref_oor;
    zero_q <= ref_zero;
    pre_q  <= pre;
    ip_q   <= ratio[apdc_pkg::QUO_W-1 -: apdc_pkg::IP_W];
    frac_q <= ratio[apdc_pkg::QUO_W-apdc_pkg::IP_W-1 -: apdc_pkg::FRAC_W];
  end

  assign done_o             = done_q;
  assign scaler_index_o     = sel_q;
  assign no_scaler_found_o  = nsf_q;
  assign ref_out_of_range_o = oor_q;
  assign ref_is_zero_o      = zero_q;
  assign pre_divide_o       = pre_q;
  assign ratio_int_o        = ip_q;
  assign ratio_frac_o       = frac_q;

endmodule

/* sv/audio_pll_divider_calc.sv */
// Top level of the audio PLL divider calculator: config registers and pipeline.
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  --------------------------------------
//   request   start_i (busy_o low)      ref_clock_hz_i, sample_rate_hz_i
//   result    done_o, one cycle         scaler_index_o .. frac_low_o
//   config    cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item enters every cycle; busy_o stays low. The selection register loads
// at the edge that accepts an item; 15 divider stages then carry the 60-step
// long division at four steps each, and the result register follows them.
// Reset clears all valid bits and loads the register defaults; results
// cannot be stalled, so the pipeline always advances.
module audio_pll_divider_calc (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [apdc_pkg::REF_W-1:0]         ref_clock_hz_i,
  input  logic [apdc_pkg::FS_W-1:0]          sample_rate_hz_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [apdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [apdc_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  output logic                               done_o,
  output logic [apdc_pkg::SEL_W-1:0]         scaler_index_o,
  output logic                               no_scaler_found_o,
  output logic                               ref_out_of_range_o,
  output logic                               ref_is_zero_o,
  output logic                               pre_divide_o,
  output logic [apdc_pkg::IP_W-1:0]          ratio_int_o,
  output logic [apdc_pkg::FRAC_W-1:0]        ratio_frac_o,
  output logic [5:0]                         frac_high_o,
  output logic [8:0]                         frac_mid_o,
  output logic [8:0]                         frac_low_o
);

  logic [31:0]                   vco_min_q, vco_max_q;
  logic [apdc_pkg::REF_W-1:0]    ref_min_q, ref_max_q;
  logic [apdc_pkg::IP_W-1:0]     ip_min_q;
  logic                          pipe_vld [apdc_pkg::DIV_STAGES+1];
  apdc_pkg::div_t                pipe_stg [apdc_pkg::DIV_STAGES+1];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vco_min_q <= apdc_pkg::VCO_MIN_RST;
      vco_max_q <= apdc_pkg::VCO_MAX_RST;
      ref_min_q <= apdc_pkg::REF_MIN_RST;
      ref_max_q <= apdc_pkg::REF_MAX_RST;
      ip_min_q  <= apdc_pkg::IP_MIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        apdc_pkg::REG_VCO_MIN: vco_min_q <= cfg_data_i;
        apdc_pkg::REG_VCO_MAX: vco_max_q <= cfg_data_i;
        apdc_pkg::REG_REF_MIN: ref_min_q <= cfg_data_i[apdc_pkg::REF_W-1:0];
        apdc_pkg::REG_REF_MAX: ref_max_q <= cfg_data_i[apdc_pkg::REF_W-1:0];
        apdc_pkg::REG_IP_MIN:  ip_min_q  <= cfg_data_i[apdc_pkg::IP_W-1:0];
        default: ;
      endcase
    end
  end

  // Target selection stage.
  apdc_select u_select (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vld_i            (start_i && !busy_o),
    .ref_clock_hz_i   (ref_clock_hz_i),
    .sample_rate_hz_i (sample_rate_hz_i),
    .vco_min_i        (vco_min_q),
    .vco_max_i        (vco_max_q),
    .ref_min_i        (ref_min_q),
    .ref_max_i        (ref_max_q),
    .vld_o            (pipe_vld[0]),
    .stg_o            (pipe_stg[0])
  );

  // Divider stages.
  for (genvar g = 0; g < apdc_pkg::DIV_STAGES; g++) begin : g_div
    apdc_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (pipe_vld[g]),
      .stg_i  (pipe_stg[g]),
      .vld_o  (pipe_vld[g+1]),
      .stg_o  (pipe_stg[g+1])
    );
  end

  // Result stage.
  apdc_finish u_finish (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .vld_i              (pipe_vld[apdc_pkg::DIV_STAGES]),
    .stg_i              (pipe_stg[apdc_pkg::DIV_STAGES]),
    .ip_min_i           (ip_min_q),
    .done_o             (done_o),
    .scaler_index_o     (scaler_index_o),
    .no_scaler_found_o  (no_scaler_found_o),
    .ref_out_of_range_o (ref_out_of_range_o),
    .ref_is_zero_o      (ref_is_zero_o),
    .pre_divide_o       (pre_divide_o),
    .ratio_int_o        (ratio_int_o),
    .ratio_frac_o       (ratio_frac_o)
  );

  // K1, K2 and K3 words of the fraction.
  assign frac_high_o = ratio_frac_o[23:18];
  assign frac_mid_o  = ratio_frac_o[17:9];
  assign frac_low_o  = ratio_frac_o[8:0];

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the audio PLL divider calculator: directed table, then random items.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import apdc_pkg::*;

  localparam int unsigned PIPE_LAT    = DIV_STAGES + 2;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS = 118;
  localparam int unsigned NUM_RATES   = 14;
  localparam int unsigned NUM_REGS    = 2 ** CFG_IDX_W;

  // Master clock scalers, in tenths.
  localparam logic [6:0] SCALERS [NUM_SCL] = '{7'd10, 7'd15, 7'd20, 7'd30,
                                               7'd40, 7'd60, 7'd80, 7'd120};

  // Common audio sample rates in Hz.
  localparam logic [FS_W-1:0] AUDIO_RATES [NUM_RATES] = '{
    18'd8000, 18'd11025, 18'd12000, 18'd16000, 18'd22050, 18'd24000, 18'd32000,
    18'd44100, 18'd48000, 18'd64000, 18'd88200, 18'd96000, 18'd176400, 18'd192000
  };

  // Register settings used by the random phases.
  typedef enum int {
    SET_DEFAULT,
    SET_OPEN,
    SET_CLOSED,
    SET_RANDOM,
    SET_EDGE
  } setting_e;

  // One ratio result, as it appears on the result ports.
  typedef struct packed {
    logic [SEL_W-1:0]  scaler_idx;
    logic              no_scaler;
    logic              ref_oor;
    logic              ref_zero;
    logic              pre_div;
    logic [IP_W-1:0]   ratio_int;
    logic [FRAC_W-1:0] ratio_frac;
    logic [5:0]        frac_high;
    logic [8:0]        frac_mid;
    logic [8:0]        frac_low;
  } pll_ratio_t;

  typedef struct packed {
    logic [REF_W-1:0] ref_hz;
    logic [FS_W-1:0]  fs_hz;
    logic             typed;
    pll_ratio_t       ratio;
  } dir_row_t;

  localparam pll_ratio_t NO_RATIO = '0;
  localparam int unsigned NUM_DIR = 23;

  // Directed items at reset settings. Typed rows carry results read straight off
  // the spec; the others go through the predictor.
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    // Zero reference and zero rate: nothing found, ratio suppressed.
    '{26'd0, 18'd0, 1'b1,
      '{3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 24'd0, 6'd0, 9'd0, 9'd0}},
    // Exact ratio of eight.
    '{26'd12288000, 18'd48000, 1'b1,
      '{3'd2, 1'b0, 1'b0, 1'b0, 1'b0, 4'd8, 24'd0, 6'd0, 9'd0, 9'd0}},
    // Ratio of four is doubled to eight.
    '{26'd24576000, 18'd48000, 1'b1,
      '{3'd2, 1'b0, 1'b0, 1'b0, 1'b1, 4'd8, 24'd0, 6'd0, 9'd0, 9'd0}},
    // No scaler found: zero ratio still gets the pre-divide flag.
    '{26'd24000000, 18'd0, 1'b1,
      '{3'd0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 24'd0, 6'd0, 9'd0, 9'd0}},
    // Zero reference with a valid scaler.
    '{26'd0, 18'd48000, 1'b1,
      '{3'd2, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0, 24'd0, 6'd0, 9'd0, 9'd0}},
    // Largest sample rate overshoots every window.
    '{26'd12288000, 18'd262143, 1'b1,
      '{3'd0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 24'd0, 6'd0, 9'd0, 9'd0}},
    '{26'd67108863, 18'd48000, 1'b0, NO_RATIO},
    '{26'd1, 18'd48000, 1'b0, NO_RATIO},
    '{26'd7999999, 18'd48000, 1'b0, NO_RATIO},
    '{26'd8000000, 18'd48000, 1'b0, NO_RATIO},
    '{26'd33000000, 18'd48000, 1'b0, NO_RATIO},
    '{26'd33000001, 18'd48000, 1'b0, NO_RATIO},
    '{26'd11289600, 18'd44100, 1'b0, NO_RATIO},
    '{26'd12288000, 18'd96000, 1'b0, NO_RATIO},
    '{26'd12288000, 18'd64000, 1'b0, NO_RATIO},
    '{26'd12288000, 18'd32000, 1'b0, NO_RATIO},
    '{26'd12288000, 18'd24000, 1'b0, NO_RATIO},
    '{26'd12288000, 18'd16000, 1'b0, NO_RATIO},
    '{26'd12288000, 18'd12000, 1'b0, NO_RATIO},
    '{26'd12288000, 18'd8000, 1'b0, NO_RATIO},
    '{26'd19200000, 18'd44100, 1'b0, NO_RATIO},
    '{26'd67108863, 18'd262143, 1'b0, NO_RATIO},
    '{26'd3, 18'd8000, 1'b0, NO_RATIO}
  };

  // Settings and sender idling for each random phase.
  localparam setting_e PHASE_SET [NUM_PHASES] = '{
    SET_RANDOM, SET_OPEN, SET_CLOSED, SET_RANDOM, SET_EDGE,
    SET_RANDOM, SET_DEFAULT, SET_RANDOM, SET_OPEN, SET_RANDOM
  };
  localparam int unsigned PHASE_IDLE [NUM_PHASES] = '{0, 82, 23, 82, 0, 23, 82, 0, 23, 82};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [REF_W-1:0]     ref_clock_hz_i = '0;
  logic [FS_W-1:0]      sample_rate_hz_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 done_o;
  logic [SEL_W-1:0]     scaler_index_o;
  logic                 no_scaler_found_o;
  logic                 ref_out_of_range_o;
  logic                 ref_is_zero_o;
  logic                 pre_divide_o;
  logic [IP_W-1:0]      ratio_int_o;
  logic [FRAC_W-1:0]    ratio_frac_o;
  logic [5:0]           frac_high_o;
  logic [8:0]           frac_mid_o;
  logic [8:0]           frac_low_o;

  // Typed result riding along with the item on the input ports.
  logic       use_typed = 1'b0;
  pll_ratio_t typed_ratio = '0;

  // Mirror of the configuration registers.
  logic [31:0]      vco_min_hz = VCO_MIN_RST;
  logic [31:0]      vco_max_hz = VCO_MAX_RST;
  logic [REF_W-1:0] ref_min_hz = REF_MIN_RST;
  logic [REF_W-1:0] ref_max_hz = REF_MAX_RST;
  logic [IP_W-1:0]  int_min    = IP_MIN_RST;

  pll_ratio_t  ratio_q [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;

  audio_pll_divider_calc DUT (.*);

  always #10 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Expected ratio result for one request under the current register settings.
  function automatic pll_ratio_t calc_pll_ratio(input logic [REF_W-1:0] ref_hz,
                                                input logic [FS_W-1:0] fs_hz);
    logic [63:0] tgt;
    logic [63:0] best;
    logic [63:0] ratio;
    pll_ratio_t  res;
    best = '0;
    ratio = '0;
    res = '0;
    res.no_scaler = 1'b1;
    // Keep the largest target strictly inside the window.
    for (int i = 0; i < NUM_SCL; i++) begin
      tgt = (64'd1024 * fs_hz * SCALERS[i]) / 64'd10;
      if (tgt > 64'(vco_min_hz) && tgt < 64'(vco_max_hz) && tgt > best) begin
        best = tgt;
        res.scaler_idx = SEL_W'(i);
        res.no_scaler = 1'b0;
      end
    end
    res.ref_zero = (ref_hz == '0);
    res.ref_oor = (ref_hz > ref_max_hz) || (ref_hz < ref_min_hz);
    // Divide and double when the integer part falls short.
    if (ref_hz != '0) begin
      ratio = (best << 28) / 64'(ref_hz);
      if (ratio[31:28] < int_min) begin
        ratio = ratio << 1;
        res.pre_div = 1'b1;
      end
    end
    res.ratio_int = ratio[31:28];
    res.ratio_frac = ratio[27:4];
    res.frac_high = res.ratio_frac[23:18];
    res.frac_mid = res.ratio_frac[17:9];
    res.frac_low = res.ratio_frac[8:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result checking, prediction of accepted items and register mirroring.
  always @(posedge clk_i) begin
    pll_ratio_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (ratio_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual ratio_int %0d frac %0d",
                     $time, ratio_int_o, ratio_frac_o);
        end else begin
          want = ratio_q.pop_front();
          check_field("scaler_index", 32'(want.scaler_idx), 32'(scaler_index_o));
          check_field("no_scaler_found", 32'(want.no_scaler), 32'(no_scaler_found_o));
          check_field("ref_out_of_range", 32'(want.ref_oor), 32'(ref_out_of_range_o));
          check_field("ref_is_zero", 32'(want.ref_zero), 32'(ref_is_zero_o));
          check_field("pre_divide", 32'(want.pre_div), 32'(pre_divide_o));
          check_field("ratio_int", 32'(want.ratio_int), 32'(ratio_int_o));
          check_field("ratio_frac", 32'(want.ratio_frac), 32'(ratio_frac_o));
          check_field("frac_high", 32'(want.frac_high), 32'(frac_high_o));
          check_field("frac_mid", 32'(want.frac_mid), 32'(frac_mid_o));
          check_field("frac_low", 32'(want.frac_low), 32'(frac_low_o));
        end
      end
      if (start_i && !busy_o)
        ratio_q.push_back(use_typed ? typed_ratio
                                    : calc_pll_ratio(ref_clock_hz_i, sample_rate_hz_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_VCO_MIN: vco_min_hz = cfg_data_i;
          REG_VCO_MAX: vco_max_hz = cfg_data_i;
          REG_REF_MIN: ref_min_hz = cfg_data_i[REF_W-1:0];
          REG_REF_MAX: ref_max_hz = cfg_data_i[REF_W-1:0];
          REG_IP_MIN:  int_min = cfg_data_i[IP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Presents one item and returns at the edge that accepts it.
  task automatic issue_item(input logic [REF_W-1:0] ref_hz, input logic [FS_W-1:0] fs_hz,
                            input logic typed, input pll_ratio_t ratio);
    ref_clock_hz_i <= ref_hz;
    sample_rate_hz_i <= fs_hz;
    use_typed <= typed;
    typed_ratio <= ratio;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Sender idling between items.
  task automatic idle_gap();
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic wait_drain();
    do @(posedge clk_i); while (ratio_q.size() != 0);
  endtask

  task automatic apply_setting(input setting_e set);
    logic [31:0] lo;
    case (set)
      SET_DEFAULT: begin
        write_reg(REG_VCO_MIN, VCO_MIN_RST);
        write_reg(REG_VCO_MAX, VCO_MAX_RST);
        write_reg(REG_REF_MIN, 32'(REF_MIN_RST));
        write_reg(REG_REF_MAX, 32'(REF_MAX_RST));
        write_reg(REG_IP_MIN, 32'(IP_MIN_RST));
      end
      SET_OPEN: begin
        // Widest window; upper data bits of the narrow registers are dropped.
        write_reg(REG_VCO_MIN, 32'd0);
        write_reg(REG_VCO_MAX, 32'hFFFF_FFFF);
        write_reg(REG_REF_MIN, 32'hFC00_0000);
        write_reg(REG_REF_MAX, 32'hFFFF_FFFF);
        write_reg(REG_IP_MIN, 32'hFFFF_FFFF);
      end
      SET_CLOSED: begin
        // Empty window and a single legal reference; no doubling.
        lo = $urandom;
        write_reg(REG_VCO_MIN, lo);
        write_reg(REG_VCO_MAX, lo);
        lo = $urandom_range(8000000, 33000000);
        write_reg(REG_REF_MIN, lo);
        write_reg(REG_REF_MAX, lo);
        write_reg(REG_IP_MIN, 32'd0);
      end
      SET_RANDOM: begin
        lo = $urandom_range(150000000);
        write_reg(REG_VCO_MIN, lo);
        write_reg(REG_VCO_MAX, lo + $urandom_range(1, 150000000));
        write_reg(REG_REF_MIN, {6'($urandom), 26'($urandom_range(12000000))});
        write_reg(REG_REF_MAX, {6'($urandom), 26'($urandom_range(20000000, 67108863))});
        write_reg(REG_IP_MIN, $urandom);
      end
      default: begin
        // Window bounds equal to real targets, which must be excluded.
        write_reg(REG_VCO_MIN, 32'd98304000);
        write_reg(REG_VCO_MAX, 32'd196608000);
        write_reg(REG_REF_MIN, 32'd0);
        write_reg(REG_REF_MAX, 32'd33000000);
        write_reg(REG_IP_MIN, 32'd1);
        // Writes to unused indexes must leave every register alone.
        for (int k = int'(REG_IP_MIN) + 1; k < NUM_REGS; k++)
          write_reg(CFG_IDX_W'(k), $urandom);
      end
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [FS_W-1:0] pick_rate();
    case ($urandom_range(9))
      0: return FS_W'($urandom);
      1: return FS_W'($urandom_range(1000, 200000));
      default: return AUDIO_RATES[$urandom_range(NUM_RATES - 1)];
    endcase
  endfunction

  function automatic logic [REF_W-1:0] pick_ref();
    case ($urandom_range(11))
      0: return REF_W'($urandom);
      1: return '0;
      2: return REF_W'($urandom_range(1, 16));
      default: return REF_W'($urandom_range(8000000, 33000000));
    endcase
  endfunction

  // Stimulus.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TAB[i])
      issue_item(DIR_TAB[i].ref_hz, DIR_TAB[i].fs_hz, DIR_TAB[i].typed, DIR_TAB[i].ratio);

    for (int p = 0; p < NUM_PHASES; p++) begin
      start_i <= 1'b0;
      wait_drain();
      apply_setting(PHASE_SET[p]);
      idle_pct = PHASE_IDLE[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_gap();
        issue_item(pick_ref(), pick_rate(), 1'b0, NO_RATIO);
      end
    end

    start_i <= 1'b0;
    wait_drain();
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (err_cnt == 0 && ratio_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/apdc_pkg.sv
sv/apdc_select.sv
sv/apdc_div_stage.sv
sv/apdc_finish.sv
sv/audio_pll_divider_calc.sv
bench/tb_top.sv
